// File: rtl/fcd_pkg.sv
// Shared constants, types and helpers for the capped cylinder distance block.
`timescale 1ns / 1ps

package fcd_pkg;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam int UQ = 30;
  localparam int GW = FB + 2;
  localparam int DW = CB + 1;
  localparam int EW = UQ + 2;
  localparam int HW = CB + 2;
  localparam int VW = CB + 16;
  localparam int MW = 31;
  localparam int RW = 32;
  localparam int SW = 5;
  localparam int NW = VW + 2;
  localparam int QW = UQ + 1;
  localparam int SQ_STAGES = RW / 2;
  localparam int DV_STAGES = (QW + 1) / 2;
  localparam int IW = 3;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam int QLW = 3;

  localparam logic [CB-1:0] ONE_RST = CB'(1 << FB);
  localparam logic [CB-2:0] RADIUS_RST = (CB-1)'(1 << FB);
  localparam logic [CB-2:0] SLAB_RST = (CB-1)'(((1 << FB) + 5) / 10);

  localparam logic signed [EW+3:0] G_ONE = (EW+4)'(1 << FB);
  localparam logic signed [EW+3:0] G_HALF = (EW+4)'(1 << (UQ - FB - 1));

  typedef enum logic [IW-1:0] {
    R_ORIGIN_X, R_ORIGIN_Y, R_ORIGIN_Z, R_AXIS_X, R_AXIS_Y, R_AXIS_Z, R_RADIUS, R_SLAB
  } reg_idx_t;

  typedef enum logic [1:0] {RG_CORNER, RG_SIDE, RG_CAP} region_t;
  typedef enum logic [1:0] {ST_OK, ST_ON_AXIS, ST_ZERO_AXIS} status_t;

  typedef struct packed {
    logic [2:0][CB-1:0] origin;
    logic [2:0][CB-1:0] axis;
    logic [CB-2:0]      radius;
    logic [CB-2:0]      slab;
  } cfg_t;

  typedef struct packed {
    logic               zero_axis;
    logic [CB-2:0]      radius;
    logic [CB-2:0]      slab;
    logic [2:0][CB-1:0] axis;
    logic [2:0][DW-1:0] d;
    logic [2:0][EW-1:0] u;
    logic [HW-1:0]      hs;
    logic               on_axis;
    logic [2:0][EW-1:0] e;
    logic [VW-1:0]      dc;
    logic [VW-1:0]      dp;
    logic               upper;
  } ctx_t;

  function automatic logic signed [GW-1:0] to_grad(input logic signed [EW+3:0] x);
    logic signed [EW+3:0] r;
    r = (x + G_HALF) >>> (UQ - FB);
    if (r > G_ONE) r = G_ONE;
    if (r < -G_ONE) r = -G_ONE;
    return GW'(r);
  endfunction

endpackage

// File: rtl/finite_cylinder_distance_gradient.sv
// Top level: setup registers, front end, item queue and arithmetic back end.
//
//   channel   handshake            payload
//   point     start / busy         point_x, point_y, point_z
//   result    done (one cycle)     distance, grad_x, grad_y, grad_z, region, status
//   setup     cfg_we               cfg_index, cfg_data
//
// One point is taken per cycle while busy is low; each accepted point yields one done pulse.
// The back end chains three norm units, each a 16-stage square root and a
// 16-stage divider running two bits per stage.
// rst is synchronous and restores the default setup; queued items are dropped.
// busy rises only if the queue fills, which the back end never allows.
`timescale 1ns / 1ps

module finite_cylinder_distance_gradient (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [fcd_pkg::IW-1:0]        cfg_index,
  input  logic [fcd_pkg::CB-1:0]        cfg_data,
  input  logic signed [fcd_pkg::CB-1:0] point_x,
  input  logic signed [fcd_pkg::CB-1:0] point_y,
  input  logic signed [fcd_pkg::CB-1:0] point_z,
  output logic                          done,
  output logic signed [fcd_pkg::CB-1:0] distance,
  output logic signed [fcd_pkg::GW-1:0] grad_x,
  output logic signed [fcd_pkg::GW-1:0] grad_y,
  output logic signed [fcd_pkg::GW-1:0] grad_z,
  output logic [1:0]                    region,
  output logic [1:0]                    status
);
  import fcd_pkg::*;

  cfg_t           cfg;
  logic           q_push;
  ctx_t           q_din;
  logic           q_vld;
  ctx_t           q_dout;
  logic [QLW-1:0] q_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin <= '0;
      cfg.axis   <= {ONE_RST, CB'(0), CB'(0)};
      cfg.radius <= RADIUS_RST;
      cfg.slab   <= SLAB_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        R_ORIGIN_X: cfg.origin[0] <= cfg_data;
        R_ORIGIN_Y: cfg.origin[1] <= cfg_data;
        R_ORIGIN_Z: cfg.origin[2] <= cfg_data;
        R_AXIS_X:   cfg.axis[0]   <= cfg_data;
        R_AXIS_Y:   cfg.axis[1]   <= cfg_data;
        R_AXIS_Z:   cfg.axis[2]   <= cfg_data;
        R_RADIUS:   cfg.radius    <= cfg_data[CB-2:0];
        R_SLAB:     cfg.slab      <= cfg_data[CB-2:0];
        default: ;
      endcase
    end
  end

  fcd_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .cfg(cfg), .q_level(q_level), .q_push(q_push), .q_din(q_din)
  );

  fcd_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_din),
    .out_vld(q_vld), .dout(q_dout), .level(q_level)
  );

  fcd_back u_back (
    .clk(clk), .rst(rst), .in_vld(q_vld), .in_ctx(q_dout),
    .done(done), .distance(distance),
    .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
    .region(region), .status(status)
  );

endmodule

// File: rtl/fcd_unit3.sv
// Pipelined norm and unit vector of a 3D vector: shift, squares, sum, root, three dividers.
`timescale 1ns / 1ps

module fcd_unit3 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_vld,
  input  logic signed [fcd_pkg::VW-1:0]  in_v [3],
  input  fcd_pkg::ctx_t                  in_ctx,
  output logic                           out_vld,
  output logic [fcd_pkg::NW-1:0]         out_norm,
  output logic signed [fcd_pkg::EW-1:0]  out_e [3],
  output fcd_pkg::ctx_t                  out_ctx
);
  import fcd_pkg::*;

  typedef struct packed {
    ctx_t               ctx;
    logic [2:0]         neg;
    logic [2:0][MW-1:0] ms;
    logic [SW-1:0]      s;
  } cry_t;

  typedef struct packed {
    cry_t                 c;
    logic [2:0][2*MW-1:0] sq;
  } sqr_t;

  typedef struct packed {
    cry_t            c;
    logic [2*RW-1:0] n;
  } sum_t;

  typedef struct packed {
    cry_t            c;
    logic [2*RW+1:0] rem;
    logic [RW-1:0]   root;
  } rt_t;

  typedef struct packed {
    cry_t          c;
    logic [RW-1:0] root;
    logic [RW:0]   rc;
  } rc_t;

  typedef struct packed {
    cry_t               c;
    logic [RW-1:0]      root;
    logic [RW:0]        rc;
    logic [2:0][RW+1:0] rem;
    logic [2:0][QW-1:0] q;
  } dv_t;

  function automatic rt_t sq_step(input rt_t x, input int j);
    rt_t             y;
    logic [2*RW+1:0] t;
    y = x;
    t = ((2*RW+2)'(x.root) << (j + 1)) + ((2*RW+2)'(1) << (2 * j));
    if (x.rem >= t) begin
      y.rem  = x.rem - t;
      y.root = x.root | (RW'(1) << j);
    end
    return y;
  endfunction

  function automatic dv_t dv_step(input dv_t x, input int j);
    dv_t           y;
    logic [RW+1:0] r2;
    y = x;
    if (j >= 0) begin
      for (int i = 0; i < 3; i++) begin
        r2 = {x.rem[i][RW:0], (j == UQ) ? x.c.ms[i][0] : 1'b0};
        if (r2 >= (RW+2)'(x.rc)) begin
          r2 = r2 - (RW+2)'(x.rc);
          y.q[i][j] = 1'b1;
        end
        y.rem[i] = r2;
      end
    end
    return y;
  endfunction

  logic [VW-1:0] mg [3];
  logic [VW-1:0] mor;
  cry_t          p_next;
  rt_t           rt_init;
  dv_t           dv_init;

  cry_t                   p_c;
  logic                   p_vld;
  sqr_t                   q_r;
  logic                   q_vld;
  sum_t                   n_r;
  logic                   n_vld;
  rt_t                    rt [SQ_STAGES];
  logic [SQ_STAGES-1:0]   rt_vld;
  rc_t                    c_r;
  logic                   c_vld;
  dv_t                    dv [DV_STAGES];
  logic [DV_STAGES-1:0]   dv_vld;

  always_comb begin
    p_next.ctx = in_ctx;
    for (int i = 0; i < 3; i++) begin
      mg[i] = in_v[i][VW-1] ? VW'(-in_v[i]) : VW'(in_v[i]);
      p_next.neg[i] = in_v[i][VW-1];
    end
    mor = mg[0] | mg[1] | mg[2];
    p_next.s = '0;
    for (int b = MW; b < VW; b++) begin
      if (mor[b]) p_next.s = SW'(b - MW + 1);
    end
    for (int i = 0; i < 3; i++) begin
      p_next.ms[i] = MW'(mg[i] >> p_next.s);
    end

    rt_init.c    = n_r.c;
    rt_init.rem  = (2*RW+2)'(n_r.n);
    rt_init.root = '0;

    dv_init.c    = c_r.c;
    dv_init.root = c_r.root;
    dv_init.rc   = c_r.rc;
    dv_init.q    = '0;
    for (int i = 0; i < 3; i++) begin
      dv_init.rem[i] = (RW+2)'(c_r.c.ms[i] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    p_c <= p_next;

    q_r.c <= p_c;
    for (int i = 0; i < 3; i++) begin
      q_r.sq[i] <= (2*MW)'(p_c.ms[i]) * (2*MW)'(p_c.ms[i]);
    end

    n_r.c <= q_r.c;
    n_r.n <= (2*RW)'(q_r.sq[0]) + (2*RW)'(q_r.sq[1]) + (2*RW)'(q_r.sq[2]);

    rt[0] <= sq_step(sq_step(rt_init, RW - 1), RW - 2);
    for (int st = 1; st < SQ_STAGES; st++) begin
      rt[st] <= sq_step(sq_step(rt[st-1], RW - 1 - 2 * st), RW - 2 - 2 * st);
    end

    c_r.c    <= rt[SQ_STAGES-1].c;
    c_r.root <= rt[SQ_STAGES-1].root;
    c_r.rc   <= (RW+1)'(rt[SQ_STAGES-1].root) + (RW+1)'(rt[SQ_STAGES-1].rem != '0);

    dv[0] <= dv_step(dv_step(dv_init, QW - 1), QW - 2);
    for (int st = 1; st < DV_STAGES; st++) begin
      dv[st] <= dv_step(dv_step(dv[st-1], QW - 1 - 2 * st), QW - 2 - 2 * st);
    end

    out_ctx  <= dv[DV_STAGES-1].c.ctx;
    out_norm <= NW'(dv[DV_STAGES-1].root) << dv[DV_STAGES-1].c.s;
    for (int i = 0; i < 3; i++) begin
      if (dv[DV_STAGES-1].rc == '0) out_e[i] <= '0;
      else if (dv[DV_STAGES-1].c.neg[i]) out_e[i] <= -EW'(dv[DV_STAGES-1].q[i]);
      else out_e[i] <= EW'(dv[DV_STAGES-1].q[i]);
    end

    if (rst) begin
      p_vld   <= 1'b0;
      q_vld   <= 1'b0;
      n_vld   <= 1'b0;
      rt_vld  <= '0;
      c_vld   <= 1'b0;
      dv_vld  <= '0;
      out_vld <= 1'b0;
    end else begin
      p_vld   <= in_vld;
      q_vld   <= p_vld;
      n_vld   <= q_vld;
      rt_vld  <= {rt_vld[SQ_STAGES-2:0], n_vld};
      c_vld   <= rt_vld[SQ_STAGES-1];
      dv_vld  <= {dv_vld[DV_STAGES-2:0], c_vld};
      out_vld <= dv_vld[DV_STAGES-1];
    end
  end

endmodule

// File: rtl/fcd_front.sv
// Front end: accept a point, snapshot the setup, form the offset and flag a zero axis.
`timescale 1ns / 1ps

module fcd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [fcd_pkg::CB-1:0] point_x,
  input  logic signed [fcd_pkg::CB-1:0] point_y,
  input  logic signed [fcd_pkg::CB-1:0] point_z,
  input  fcd_pkg::cfg_t                 cfg,
  input  logic [fcd_pkg::QLW-1:0]       q_level,
  output logic                          q_push,
  output fcd_pkg::ctx_t                 q_din
);
  import fcd_pkg::*;

  logic signed [CB-1:0] pt [3];
  ctx_t                 ctx_next;
  logic                 take;

  assign busy = ((QLW+1)'(q_level) + (QLW+1)'(q_push)) >= (QLW+1)'(QDEPTH);
  assign take = start && !busy;

  always_comb begin
    pt[0] = point_x;
    pt[1] = point_y;
    pt[2] = point_z;
    ctx_next = '0;
    ctx_next.zero_axis = (cfg.axis == '0);
    ctx_next.radius    = cfg.radius;
    ctx_next.slab      = cfg.slab;
    ctx_next.axis      = cfg.axis;
    for (int i = 0; i < 3; i++) begin
      ctx_next.d[i] = DW'(pt[i]) - DW'($signed(cfg.origin[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (take) q_din <= ctx_next;
    if (rst) q_push <= 1'b0;
    else q_push <= take;
  end

endmodule

// File: rtl/fcd_queue.sv
// Short item queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module fcd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  fcd_pkg::ctx_t           din,
  output logic                    out_vld,
  output fcd_pkg::ctx_t           dout,
  output logic [fcd_pkg::QLW-1:0] level
);
  import fcd_pkg::*;

  ctx_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  assign out_vld = (level != '0);
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (out_vld) rd_ptr <= rd_ptr + QAW'(1);
      level <= level + QLW'(push) - QLW'(out_vld);
    end
  end

endmodule

// File: rtl/fcd_back.sv
// Back end: unit axis, height and side offset, side norm, corner norm, result select.
`timescale 1ns / 1ps

module fcd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  fcd_pkg::ctx_t                 in_ctx,
  output logic                          done,
  output logic signed [fcd_pkg::CB-1:0] distance,
  output logic signed [fcd_pkg::GW-1:0] grad_x,
  output logic signed [fcd_pkg::GW-1:0] grad_y,
  output logic signed [fcd_pkg::GW-1:0] grad_z,
  output logic [1:0]                    region,
  output logic [1:0]                    status
);
  import fcd_pkg::*;

  localparam logic signed [NW:0] DMAX = (NW+1)'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [NW:0] DMIN = -DMAX - (NW+1)'(1);

  logic signed [VW-1:0] a_v [3];
  logic                 u1_vld;
  logic signed [EW-1:0] u1_e [3];
  ctx_t                 u1_ctx;

  ctx_t                    c1_next;
  logic                    b1_vld;
  ctx_t                    b1_c;
  logic signed [EW+DW-1:0] b1_p [3];

  logic signed [EW+DW+1:0] acc;
  ctx_t                    c2_next;
  logic                    b2_vld;
  ctx_t                    b2_c;

  logic                    b3_vld;
  ctx_t                    b3_c;
  logic signed [HW+EW-1:0] b3_hu [3];

  logic signed [VW-1:0] ws_next [3];
  ctx_t                 c4_next;
  logic                 b4_vld;
  ctx_t                 b4_c;
  logic signed [VW-1:0] b4_ws [3];

  logic                 u2_vld;
  logic [NW-1:0]        u2_norm;
  logic signed [EW-1:0] u2_e [3];
  ctx_t                 u2_ctx;

  ctx_t                 c5_next;
  logic                 b5_vld;
  ctx_t                 b5_c;
  logic signed [VW-1:0] cd_v [3];

  logic                 u3_vld;
  logic [NW-1:0]        u3_norm;
  logic signed [EW-1:0] u3_e [3];
  ctx_t                 u3_ctx;

  logic                   b6_vld;
  ctx_t                   b6_c;
  logic [NW-1:0]          b6_norm;
  logic signed [2*EW-1:0] b6_ce [3];
  logic signed [2*EW-1:0] b6_cu [3];

  logic                   corner;
  logic signed [2*EW:0]   sm [3];
  logic signed [EW+3:0]   gsel [3];
  logic signed [GW-1:0]   gq [3];
  logic signed [NW:0]     dcand;
  logic [1:0]             rg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_v[i] = VW'($signed(in_ctx.axis[i]));
    end
  end

  fcd_unit3 u_axis (
    .clk(clk), .rst(rst), .in_vld(in_vld), .in_v(a_v), .in_ctx(in_ctx),
    .out_vld(u1_vld), .out_norm(), .out_e(u1_e), .out_ctx(u1_ctx)
  );

  always_comb begin
    c1_next = u1_ctx;
    for (int i = 0; i < 3; i++) begin
      c1_next.u[i] = u1_e[i];
    end
    acc = (EW+DW+2)'(b1_p[0]) + (EW+DW+2)'(b1_p[1]) + (EW+DW+2)'(b1_p[2]);
    c2_next    = b1_c;
    c2_next.hs = HW'(acc >>> UQ);
    for (int i = 0; i < 3; i++) begin
      ws_next[i] = VW'($signed(b3_c.d[i])) - VW'(b3_hu[i] >>> UQ);
    end
    c4_next         = b3_c;
    c4_next.on_axis = (ws_next[0] == '0) && (ws_next[1] == '0) && (ws_next[2] == '0);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cd_v[i] = '0;
    end
    cd_v[0] = $signed(b5_c.dc);
    cd_v[1] = $signed(b5_c.dp);

    c5_next = u2_ctx;
    for (int i = 0; i < 3; i++) begin
      c5_next.e[i] = u2_e[i];
    end
    c5_next.dc    = VW'(u2_norm) - VW'(u2_ctx.radius);
    c5_next.upper = $signed({u2_ctx.hs[HW-1], u2_ctx.hs, 1'b0})
                    > $signed((HW+2)'(u2_ctx.slab));
    c5_next.dp    = c5_next.upper ? VW'($signed(u2_ctx.hs)) - VW'(u2_ctx.slab)
                                  : -VW'($signed(u2_ctx.hs));
  end

  fcd_unit3 u_side (
    .clk(clk), .rst(rst), .in_vld(b4_vld), .in_v(b4_ws), .in_ctx(b4_c),
    .out_vld(u2_vld), .out_norm(u2_norm), .out_e(u2_e), .out_ctx(u2_ctx)
  );

  fcd_unit3 u_corner (
    .clk(clk), .rst(rst), .in_vld(b5_vld), .in_v(cd_v), .in_ctx(b5_c),
    .out_vld(u3_vld), .out_norm(u3_norm), .out_e(u3_e), .out_ctx(u3_ctx)
  );

  always_comb begin
    corner = ($signed(b6_c.dc) > 0) && ($signed(b6_c.dp) > 0);
    for (int i = 0; i < 3; i++) begin
      sm[i] = (2*EW+1)'(b6_ce[i])
              + (b6_c.upper ? (2*EW+1)'(b6_cu[i]) : -(2*EW+1)'(b6_cu[i]));
    end
    if (corner) begin
      rg    = RG_CORNER;
      dcand = $signed({1'b0, b6_norm});
      for (int i = 0; i < 3; i++) begin
        gsel[i] = (EW+4)'(sm[i] >>> UQ);
      end
    end else if ($signed(b6_c.dc) > $signed(b6_c.dp)) begin
      rg    = RG_SIDE;
      dcand = (NW+1)'($signed(b6_c.dc));
      for (int i = 0; i < 3; i++) begin
        gsel[i] = (EW+4)'($signed(b6_c.e[i]));
      end
    end else begin
      rg    = RG_CAP;
      dcand = (NW+1)'($signed(b6_c.dp));
      for (int i = 0; i < 3; i++) begin
        gsel[i] = b6_c.upper ? (EW+4)'($signed(b6_c.u[i])) : -(EW+4)'($signed(b6_c.u[i]));
      end
    end
    for (int i = 0; i < 3; i++) begin
      gq[i] = b6_c.on_axis ? '0 : to_grad(gsel[i]);
    end
  end

  always_ff @(posedge clk) begin
    b1_c <= c1_next;
    for (int i = 0; i < 3; i++) begin
      b1_p[i] <= u1_e[i] * $signed(u1_ctx.d[i]);
    end

    b2_c <= c2_next;

    b3_c <= b2_c;
    for (int i = 0; i < 3; i++) begin
      b3_hu[i] <= $signed(b2_c.hs) * $signed(b2_c.u[i]);
    end

    b4_c  <= c4_next;
    b4_ws <= ws_next;

    b5_c <= c5_next;

    b6_c    <= u3_ctx;
    b6_norm <= u3_norm;
    for (int i = 0; i < 3; i++) begin
      b6_ce[i] <= u3_e[0] * $signed(u3_ctx.e[i]);
      b6_cu[i] <= u3_e[1] * $signed(u3_ctx.u[i]);
    end

    if (b6_c.zero_axis) begin
      distance <= '0;
      grad_x   <= '0;
      grad_y   <= '0;
      grad_z   <= '0;
      region   <= RG_CORNER;
      status   <= ST_ZERO_AXIS;
    end else begin
      if (dcand > DMAX) distance <= CB'(DMAX);
      else if (dcand < DMIN) distance <= CB'(DMIN);
      else distance <= CB'(dcand);
      grad_x <= gq[0];
      grad_y <= gq[1];
      grad_z <= gq[2];
      region <= rg;
      status <= b6_c.on_axis ? ST_ON_AXIS : ST_OK;
    end

    if (rst) begin
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      b3_vld <= 1'b0;
      b4_vld <= 1'b0;
      b5_vld <= 1'b0;
      b6_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      b1_vld <= u1_vld;
      b2_vld <= b1_vld;
      b3_vld <= b2_vld;
      b4_vld <= b3_vld;
      b5_vld <= u2_vld;
      b6_vld <= u3_vld;
      done   <= b6_vld;
    end
  end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the capped cylinder distance and gradient block.
`timescale 1ns / 1ps

module tb_top;
  import fcd_pkg::*;

  localparam int LATENCY = 119;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1430;

  typedef struct packed {
    logic signed [CB-1:0] distance;
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;
    logic signed [GW-1:0] gz;
    region_t              region;
    status_t              status;
  } cyl_result_t;

  typedef struct {
    logic signed [CB-1:0] px, py, pz;
    bit                   typed;
    cyl_result_t          res;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;
  logic signed [CB-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic done;
  logic signed [CB-1:0] distance;
  logic signed [GW-1:0] grad_x, grad_y, grad_z;
  logic [1:0] region, status;

  logic [CB-1:0] shadow [8];
  cyl_result_t pending_results [$];
  int errors = 0;
  int idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  finite_cylinder_distance_gradient u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .done(done), .distance(distance), .grad_x(grad_x), .grad_y(grad_y),
    .grad_z(grad_z), .region(region), .status(status)
  );

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned unit_vec(input longint v [3], output longint e [3]);
    longint unsigned m [3];
    longint unsigned sum, r, rc, q;
    int s;
    s = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) m[i] = mag64(v[i]);
    while (s < 63 && ((m[0] >> s) | (m[1] >> s) | (m[2] >> s)) >= (64'd1 << 31)) s++;
    for (int i = 0; i < 3; i++) sum += (m[i] >> s) * (m[i] >> s);
    r = root_floor(sum);
    rc = r + ((r * r < sum) ? 1 : 0);
    for (int i = 0; i < 3; i++) begin
      q = rc != 0 ? ((m[i] >> s) << UQ) / rc : 0;
      e[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return r << s;
  endfunction

  function automatic logic signed [GW-1:0] grad_q16(longint q30);
    longint g;
    g = floor_shift(q30 + (64'sd1 << (UQ - FB - 1)), UQ - FB);
    if (g > (64'sd1 << FB)) g = 64'sd1 << FB;
    if (g < -(64'sd1 << FB)) g = -(64'sd1 << FB);
    return GW'(g);
  endfunction

  function automatic cyl_result_t predict_distance(logic signed [CB-1:0] px,
                                                   logic signed [CB-1:0] py,
                                                   logic signed [CB-1:0] pz);
    longint d [3], a [3], u [3], xs [3], ws [3], e [3], g [3], cd [3], cs [3];
    longint rad, slab, sdist, h, hs, acc, dc, dp, sg;
    longint unsigned p;
    int k;
    bit upper, onaxis;
    cyl_result_t r;
    rad = longint'(shadow[R_RADIUS][CB-2:0]);
    slab = longint'(shadow[R_SLAB][CB-2:0]);
    d[0] = longint'(px) - longint'($signed(shadow[R_ORIGIN_X]));
    d[1] = longint'(py) - longint'($signed(shadow[R_ORIGIN_Y]));
    d[2] = longint'(pz) - longint'($signed(shadow[R_ORIGIN_Z]));
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(shadow[R_AXIS_X + i]));
      g[i] = 0;
    end
    r = '0;
    if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
      r.status = ST_ZERO_AXIS;
      r.region = RG_CORNER;
      return r;
    end
    void'(unit_vec(a, u));
    k = 0;
    while (k < 63 && ((mag64(d[0]) >> k) | (mag64(d[1]) >> k) | (mag64(d[2]) >> k))
           >= (64'd1 << 32)) k++;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      xs[i] = floor_shift(d[i], k);
      acc += u[i] * xs[i];
    end
    hs = floor_shift(acc, UQ);
    h = hs * (64'sd1 << k);
    for (int i = 0; i < 3; i++) ws[i] = xs[i] - floor_shift(hs * u[i], UQ);
    onaxis = ws[0] == 0 && ws[1] == 0 && ws[2] == 0;
    p = unit_vec(ws, e) << k;
    dc = longint'(p) - rad;
    upper = 2 * h > slab;
    dp = upper ? h - slab : -h;
    sg = upper ? 1 : -1;
    if (dc > 0 && dp > 0) begin
      cd[0] = dc; cd[1] = dp; cd[2] = 0;
      sdist = longint'(unit_vec(cd, cs));
      r.region = RG_CORNER;
      for (int i = 0; i < 3; i++) g[i] = floor_shift(cs[0] * e[i] + sg * cs[1] * u[i], UQ);
    end else if (dc > dp) begin
      sdist = dc;
      r.region = RG_SIDE;
      for (int i = 0; i < 3; i++) g[i] = e[i];
    end else begin
      sdist = dp;
      r.region = RG_CAP;
      for (int i = 0; i < 3; i++) g[i] = sg * u[i];
    end
    r.status = onaxis ? ST_ON_AXIS : ST_OK;
    if (!onaxis) begin
      r.gx = grad_q16(g[0]);
      r.gy = grad_q16(g[1]);
      r.gz = grad_q16(g[2]);
    end
    if (sdist > 64'sh7fffffff) sdist = 64'sh7fffffff;
    if (sdist < -64'sh80000000) sdist = -64'sh80000000;
    r.distance = CB'(sdist);
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [CB-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    shadow[idx] = (idx >= R_RADIUS) ? {1'b0, value[CB-2:0]} : value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                            logic signed [CB-1:0] pz, bit typed, cyl_result_t typed_res);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(typed ? typed_res : predict_distance(px, py, pz));
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed(CB'($urandom_range(0, 6 << 16))) - (3 << 16);
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed(CB'($urandom_range(0, 1 << 20))) - (1 << 19);
    endcase
  endfunction

  function automatic logic [CB-1:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 0;
      default: return $signed(CB'($urandom_range(0, 1 << 18))) - (1 << 17);
    endcase
  endfunction

  always @(posedge clk) begin
    if (done && !rst) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: d=%0d", $time, distance);
        errors++;
      end else begin
        cyl_result_t want;
        want = pending_results.pop_front();
        if (distance !== want.distance || grad_x !== want.gx || grad_y !== want.gy ||
            grad_z !== want.gz || region !== want.region || status !== want.status) begin
          $display("%0t: mismatch expected d=%0d g=(%0d %0d %0d) rg=%0d st=%0d", $time,
                   want.distance, want.gx, want.gy, want.gz, want.region, want.status);
          $display("%0t:          actual   d=%0d g=(%0d %0d %0d) rg=%0d st=%0d", $time,
                   distance, grad_x, grad_y, grad_z, region, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || pending_results.size() == 0) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  point_row_t directed [$];

  initial begin
    point_row_t row;
    cyl_result_t zr;
    int mode;
    shadow[R_ORIGIN_X] = 0;
    shadow[R_ORIGIN_Y] = 0;
    shadow[R_ORIGIN_Z] = 0;
    shadow[R_AXIS_X] = 0;
    shadow[R_AXIS_Y] = 0;
    shadow[R_AXIS_Z] = ONE_RST;
    shadow[R_RADIUS] = {1'b0, RADIUS_RST};
    shadow[R_SLAB] = {1'b0, SLAB_RST};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    zr = '0;
    zr.status = ST_ZERO_AXIS;
    zr.region = RG_CORNER;
    directed = '{
      '{0, 0, 0, 0, '0},
      '{32'sh10000, 0, 32'sh800, 0, '0},
      '{32'sh30000, 0, 32'sh800, 0, '0},
      '{32'sh30000, 0, 32'sh50000, 0, '0},
      '{0, 32'sh8000, -32'sh50000, 0, '0},
      '{0, 0, 32'sh7fffffff, 0, '0},
      '{0, 0, 32'sh80000000, 0, '0},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, '0},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, '0},
      '{32'sh7fffffff, 32'sh80000000, 32'sh1234, 0, '0},
      '{-32'sh8000, 32'sh8000, 32'sh0, 0, '0},
      '{32'sh8000, -32'sh20000, 32'sh1000, 0, '0}
    };
    foreach (directed[i]) begin
      row = directed[i];
      send_point(row.px, row.py, row.pz, row.typed, row.res);
    end
    end_burst();
    drain_results();

    for (int r = R_ORIGIN_X; r <= R_SLAB; r++) write_reg(reg_idx_t'(r), 0);
    send_point(32'sh10000, 0, 0, 1, zr);
    send_point(32'sh80000000, 32'sh7fffffff, 0, 1, zr);
    end_burst();
    drain_results();

    write_reg(R_ORIGIN_X, 32'h80000000);
    write_reg(R_ORIGIN_Y, 32'h7fffffff);
    write_reg(R_ORIGIN_Z, 32'h80000000);
    write_reg(R_AXIS_X, 32'h7fffffff);
    write_reg(R_AXIS_Y, 32'h80000000);
    write_reg(R_AXIS_Z, 32'h7fffffff);
    write_reg(R_RADIUS, 32'hffffffff);
    write_reg(R_SLAB, 32'h7fffffff);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, '0);
    send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, '0);
    send_point(0, 0, 0, 0, '0);
    end_burst();
    drain_results();

    for (int phase = 0; phase < 10; phase++) begin
      for (int r = R_ORIGIN_X; r <= R_ORIGIN_Z; r++)
        write_reg(reg_idx_t'(r), phase % 3 == 0 ? $urandom() :
                  CB'($signed(CB'($urandom_range(0, 1 << 18))) - (1 << 17)));
      for (int r = R_AXIS_X; r <= R_AXIS_Z; r++) write_reg(reg_idx_t'(r), rand_axis());
      write_reg(R_RADIUS, phase == 1 ? 0 : (phase == 2 ? 32'hffffffff :
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4 << 16)));
      write_reg(R_SLAB, phase == 1 ? 0 : (phase == 2 ? 32'hffffffff :
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 4 << 16)));
      for (int n = 0; n < N_RANDOM / 10; n++) begin
        mode = $urandom_range(0, 9);
        mode = mode < 1 ? 0 : (mode < 2 ? 2 : (mode < 7 ? 1 : 3));
        if ($urandom_range(0, 19) == 0)
          send_point(CB'(shadow[R_ORIGIN_X]), CB'(shadow[R_ORIGIN_Y]),
                     CB'(shadow[R_ORIGIN_Z]) + rand_coord(1), 0, '0);
        else
          send_point(CB'(shadow[R_ORIGIN_X]) + rand_coord(mode),
                     CB'(shadow[R_ORIGIN_Y]) + rand_coord(mode),
                     CB'(shadow[R_ORIGIN_Z]) + rand_coord(mode), 0, '0);
      end
      end_burst();
      drain_results();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
